### src/fsip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsip_pkg
// Shared types and constants of the firmware segment image parser: result
// record layout, status and class codes, header geometry and memory windows.
// ----------------------------------------------------------------------------
package fsip_pkg;

  // Block header geometry
  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned HDR_CNT_W = $clog2(HDR_BYTES);

  // Memory windows for segment classification
  localparam logic [31:0] ITCM_BASE = 32'h0000_0000;
  localparam logic [31:0] TCM_SPAN  = 32'h0000_4000;
  localparam logic [31:0] DTCM_BASE = 32'h1000_4000;

  // Register word index of image_length
  localparam logic REG_IMAGE_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TRUNCATED  = 2'd1,
    STATUS_BAD_SEG    = 2'd2,
    STATUS_NO_SEGMENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLASS_INSTR    = 2'd0,
    CLASS_DATA     = 2'd1,
    CLASS_EXTERNAL = 2'd2
  } seg_class_t;

  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  segment_address;
    logic [31:0]  segment_length;
    logic [31:0]  payload_offset;
    logic [1:0]   segment_class;
    logic [3:0]   segment_number;
    logic [1:0]   parse_status;
    logic [4:0]   segments_found;
    logic [31:0]  instr_total;
    logic [31:0]  data_total;
    logic [31:0]  external_total;
  } result_rec_t;

  // True when [addr, addr+size) lies inside [base, base+span)
  function automatic logic fits(input logic [31:0] addr, input logic [31:0] size,
                                input logic [31:0] base, input logic [31:0] span);
    logic [32:0] seg_end;
    logic [32:0] win_end;
    seg_end = {1'b0, addr} + {1'b0, size};
    win_end = {1'b0, base} + {1'b0, span};
    return (addr >= base) && (seg_end <= win_end);
  endfunction

endpackage

### src/firmware_segment_image_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_segment_image_parser_unit
// Byte-stream parser for segmented firmware images with per-segment records
// and an end-of-image summary.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock cycle, sustained, for as long as
// results are drained: each byte is parsed in a single pass of logic from the
// input port into the parse registers and, when it completes a nonempty block
// header that fits or is the last image byte, into a two-entry result queue.
// A byte is a transfer on image_valid/image_ready; a result is a transfer on
// result_valid/result_ready. image_ready drops only when both queue entries
// hold results that have not been taken, so the throughput figure of one byte
// per cycle is set by the output side alone. There is no clearing pass after
// reset. Program image_length (register 0, byte address 0) only while the
// block is idle; it is the total byte count of the image, with zero standing
// for 2^32. Every nonempty block that fits image and table yields a segment
// record at its last header byte; the final byte yields a summary record with
// status, segment count and per-class byte totals, then parsing starts over.
// ----------------------------------------------------------------------------
module firmware_segment_image_parser_unit
  import fsip_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,

  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // Image byte stream
  input  logic        image_valid,
  output logic        image_ready,
  input  logic [7:0]  image_byte,

  // Result stream
  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic [31:0] segment_address,
  output logic [31:0] segment_length,
  output logic [31:0] payload_offset,
  output logic [1:0]  segment_class,
  output logic [3:0]  segment_number,
  output logic [1:0]  parse_status,
  output logic [4:0]  segments_found,
  output logic [31:0] instr_total,
  output logic [31:0] data_total,
  output logic [31:0] external_total
);

  // Segment counter must be able to hold MAX_SEGMENTS itself
  localparam int unsigned TALLY_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_SEGMENTS);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [31:0] image_length;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_IMAGE_LENGTH);
  assign prdata    = (paddr[2] == REG_IMAGE_LENGTH) ? image_length : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= 32'd1;
    end else if (cfg_write) begin
      image_length <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  logic [31:0]          byte_position,     byte_position_next;
  logic [HDR_CNT_W-1:0] header_byte_count, header_byte_count_next;
  logic [31:0]          address_assembly,  address_assembly_next;
  logic [31:0]          size_assembly,     size_assembly_next;
  logic [31:0]          payload_remaining, payload_remaining_next;
  logic                 in_payload,        in_payload_next;
  logic [TALLY_W-1:0]   segment_tally,     segment_tally_next;
  logic [31:0]          instr_sum,         instr_sum_next;
  logic [31:0]          data_sum,          data_sum_next;
  logic [31:0]          external_sum,      external_sum_next;
  status_t              error_code,        error_code_next;

  // Result queue: slot0 is the head
  result_rec_t slot0;
  result_rec_t slot1;
  logic [1:0]  count;

  logic        byte_xfer;
  logic        res_xfer;
  logic        has_result;
  result_rec_t rec;

  // Per-byte working values
  logic [31:0]        pos_plus1;
  logic               last_byte;
  logic               header_done;
  logic [31:0]        addr_cur;
  logic [31:0]        size_cur;
  logic [31:0]        bytes_left;
  status_t            final_status;
  logic [TALLY_W+4:0] tally_ext;

  assign image_ready = (count != 2'd2);
  assign byte_xfer   = image_valid && image_ready;
  assign res_xfer    = result_valid && result_ready;

  assign pos_plus1      = byte_position + 32'd1;
  assign last_byte      = (pos_plus1 == image_length);
  assign tally_ext      = {5'd0, segment_tally};

  always_comb begin
    byte_position_next     = byte_position;
    header_byte_count_next = header_byte_count;
    address_assembly_next  = address_assembly;
    size_assembly_next     = size_assembly;
    payload_remaining_next = payload_remaining;
    in_payload_next        = in_payload;
    segment_tally_next     = segment_tally;
    instr_sum_next         = instr_sum;
    data_sum_next          = data_sum;
    external_sum_next      = external_sum;
    error_code_next        = error_code;
    header_done            = 1'b0;
    addr_cur               = address_assembly;
    size_cur               = size_assembly;
    bytes_left             = image_length - pos_plus1;
    final_status           = error_code;
    has_result             = 1'b0;
    rec                    = '0;

    if (error_code == STATUS_OK) begin
      if (in_payload) begin
        // Skip payload bytes; leave the payload on its last byte
        payload_remaining_next = payload_remaining - 32'd1;
        if (payload_remaining == 32'd1) begin
          in_payload_next = 1'b0;
        end
      end else begin
        // Start a fresh header on its first byte
        if (header_byte_count == '0) begin
          addr_cur = '0;
          size_cur = '0;
        end
        for (int i = 0; i < 4; i++) begin
          if (header_byte_count == HDR_CNT_W'(i)) begin
            addr_cur[8*i +: 8] = image_byte;
          end
          if (header_byte_count == HDR_CNT_W'(i + 4)) begin
            size_cur[8*i +: 8] = image_byte;
          end
        end
        address_assembly_next  = addr_cur;
        size_assembly_next     = size_cur;
        header_done            = (header_byte_count == HDR_CNT_W'(HDR_BYTES - 1));
        header_byte_count_next = header_byte_count + HDR_CNT_W'(1);

        if (header_done && (size_cur != 32'd0)) begin
          if ((size_cur > bytes_left) || (segment_tally >= TALLY_MAX)) begin
            error_code_next = STATUS_BAD_SEG;
          end else begin
            rec.kind            = KIND_SEGMENT;
            rec.segment_address = addr_cur;
            rec.segment_length  = size_cur;
            rec.payload_offset  = pos_plus1;
            rec.segment_number  = tally_ext[3:0];
            if (fits(addr_cur, size_cur, ITCM_BASE, TCM_SPAN)) begin
              rec.segment_class = CLASS_INSTR;
              instr_sum_next    = instr_sum + size_cur;
            end else if (fits(addr_cur, size_cur, DTCM_BASE, TCM_SPAN)) begin
              rec.segment_class = CLASS_DATA;
              data_sum_next     = data_sum + size_cur;
            end else begin
              rec.segment_class = CLASS_EXTERNAL;
              external_sum_next = external_sum + size_cur;
            end
            segment_tally_next     = segment_tally + TALLY_W'(1);
            payload_remaining_next = size_cur;
            in_payload_next        = 1'b1;
            has_result             = 1'b1;
          end
        end

        // Image ends inside a header
        if (last_byte && !header_done) begin
          error_code_next = STATUS_TRUNCATED;
        end
      end
    end

    byte_position_next = pos_plus1;

    if (last_byte) begin
      // Summary replaces any segment record of this byte; no segment can be
      // added on the final byte, so the current count is the final one
      final_status = error_code_next;
      if ((final_status == STATUS_OK) && (segment_tally_next == '0)) begin
        final_status = STATUS_NO_SEGMENT;
      end
      rec                = '0;
      rec.kind           = KIND_SUMMARY;
      rec.parse_status   = final_status;
      rec.segments_found = tally_ext[4:0];
      rec.instr_total    = instr_sum_next;
      rec.data_total     = data_sum_next;
      rec.external_total = external_sum_next;
      has_result         = 1'b1;

      // Start over for the next image
      byte_position_next     = '0;
      header_byte_count_next = '0;
      address_assembly_next  = '0;
      size_assembly_next     = '0;
      payload_remaining_next = '0;
      in_payload_next        = 1'b0;
      segment_tally_next     = '0;
      instr_sum_next         = '0;
      data_sum_next          = '0;
      external_sum_next      = '0;
      error_code_next        = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      header_byte_count <= '0;
      address_assembly  <= '0;
      size_assembly     <= '0;
      payload_remaining <= '0;
      in_payload        <= 1'b0;
      segment_tally     <= '0;
      instr_sum         <= '0;
      data_sum          <= '0;
      external_sum      <= '0;
      error_code        <= STATUS_OK;
    end else if (byte_xfer) begin
      byte_position     <= byte_position_next;
      header_byte_count <= header_byte_count_next;
      address_assembly  <= address_assembly_next;
      size_assembly     <= size_assembly_next;
      payload_remaining <= payload_remaining_next;
      in_payload        <= in_payload_next;
      segment_tally     <= segment_tally_next;
      instr_sum         <= instr_sum_next;
      data_sum          <= data_sum_next;
      external_sum      <= external_sum_next;
      error_code        <= error_code_next;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry result queue
  // --------------------------------------------------------------------------
  logic push;

  assign push = byte_xfer && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, res_xfer})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Payload slots need no reset
  always_ff @(posedge clk) begin
    case ({push, res_xfer})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= rec;
        end else begin
          slot1 <= rec;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= rec;
        end else begin
          slot0 <= slot1;
          slot1 <= rec;
        end
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

  assign result_valid    = (count != 2'd0);
  assign result_kind     = slot0.kind;
  assign segment_address = slot0.segment_address;
  assign segment_length  = slot0.segment_length;
  assign payload_offset  = slot0.payload_offset;
  assign segment_class   = slot0.segment_class;
  assign segment_number  = slot0.segment_number;
  assign parse_status    = slot0.parse_status;
  assign segments_found  = slot0.segments_found;
  assign instr_total     = slot0.instr_total;
  assign data_total      = slot0.data_total;
  assign external_total  = slot0.external_total;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (payload_remaining != 32'd0))
    else $error("payload flag set with nothing left to skip");

  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    segment_tally <= TALLY_MAX)
    else $error("segment count exceeds table size");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (byte_xfer && last_byte) |=> (byte_position == 32'd0) && (segment_tally == '0)
                                  && (error_code == STATUS_OK))
    else $error("parse state not cleared after summary");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !res_xfer) |=> (count == 2'd2))
    else $error("result lost from a full queue");

endmodule

### verif/fsip_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsip_record_checker
// Watches the image byte, configuration and result channels of the firmware
// segment image parser, predicts every segment and summary record from the
// accepted bytes, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module fsip_record_checker
  import fsip_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,

  input  logic        image_valid,
  input  logic        image_ready,
  input  logic [7:0]  image_byte,

  input  logic        result_valid,
  input  logic        result_ready,
  input  logic        result_kind,
  input  logic [31:0] segment_address,
  input  logic [31:0] segment_length,
  input  logic [31:0] payload_offset,
  input  logic [1:0]  segment_class,
  input  logic [3:0]  segment_number,
  input  logic [1:0]  parse_status,
  input  logic [4:0]  segments_found,
  input  logic [31:0] instr_total,
  input  logic [31:0] data_total,
  input  logic [31:0] external_total,

  output int          mismatch_count,
  output int          records_due
);

  logic [31:0] length_reg;
  logic [31:0] byte_pos;
  logic [3:0]  hdr_count;
  logic [31:0] addr_acc;
  logic [31:0] size_acc;
  logic [31:0] payload_left;
  logic        in_payload;
  logic [31:0] seg_tally;
  logic [31:0] instr_sum;
  logic [31:0] data_sum;
  logic [31:0] ext_sum;
  status_t     fault;

  result_rec_t pending_records[$];
  result_rec_t oldest;

  // Segment [addr, addr+size) inside a TCM window starting at base
  function automatic logic in_window(input logic [31:0] addr, input logic [31:0] size,
                                     input logic [31:0] base);
    logic [63:0] stop;
    stop = 64'(addr) + 64'(size);
    return (addr >= base) && (stop <= 64'(base) + 64'(TCM_SPAN));
  endfunction

  task automatic clear_parse();
    byte_pos     = '0;
    hdr_count    = '0;
    addr_acc     = '0;
    size_acc     = '0;
    payload_left = '0;
    in_payload   = 1'b0;
    seg_tally    = '0;
    instr_sum    = '0;
    data_sum     = '0;
    ext_sum      = '0;
    fault        = STATUS_OK;
  endtask

  task automatic parse_image_byte(input logic [7:0] b);
    logic [31:0] nxt;
    logic [31:0] room;
    logic        last;
    logic        hdr_done;
    logic        emit;
    int          h;
    seg_class_t  cls;
    status_t     status;
    result_rec_t rec;
    nxt      = byte_pos + 32'd1;
    last     = (nxt == length_reg);
    hdr_done = 1'b0;
    emit     = 1'b0;
    rec      = '0;
    if (fault == STATUS_OK) begin
      if (in_payload) begin
        payload_left = payload_left - 32'd1;
        if (payload_left == 0) in_payload = 1'b0;
      end else begin
        h = hdr_count;
        if (h == 0) begin
          addr_acc = '0;
          size_acc = '0;
        end
        if (h < 4) addr_acc[8*h +: 8] = b;
        else if (h < 8) size_acc[8*(h-4) +: 8] = b;
        if (h == HDR_BYTES - 1) begin
          hdr_done  = 1'b1;
          hdr_count = '0;
        end else begin
          hdr_count = 4'(h + 1);
        end
        if (hdr_done && size_acc != 0) begin
          room = length_reg - nxt;
          if (size_acc > room || seg_tally >= MAX_SEGMENTS) begin
            fault = STATUS_BAD_SEG;
          end else begin
            if (in_window(addr_acc, size_acc, ITCM_BASE)) begin
              cls = CLASS_INSTR;
              instr_sum += size_acc;
            end else if (in_window(addr_acc, size_acc, DTCM_BASE)) begin
              cls = CLASS_DATA;
              data_sum += size_acc;
            end else begin
              cls = CLASS_EXTERNAL;
              ext_sum += size_acc;
            end
            rec.kind            = KIND_SEGMENT;
            rec.segment_address = addr_acc;
            rec.segment_length  = size_acc;
            rec.payload_offset  = nxt;
            rec.segment_class   = cls;
            rec.segment_number  = seg_tally[3:0];
            seg_tally    = seg_tally + 32'd1;
            payload_left = size_acc;
            in_payload   = 1'b1;
            emit         = 1'b1;
          end
        end
        if (last && !hdr_done && fault == STATUS_OK) fault = STATUS_TRUNCATED;
      end
    end
    byte_pos = nxt;
    if (last) begin
      status = fault;
      if (status == STATUS_OK && seg_tally == 0) status = STATUS_NO_SEGMENT;
      rec = '0;
      rec.kind           = KIND_SUMMARY;
      rec.parse_status   = status;
      rec.segments_found = seg_tally[4:0];
      rec.instr_total    = instr_sum;
      rec.data_total     = data_sum;
      rec.external_total = ext_sum;
      emit = 1'b1;
      clear_parse();
    end
    if (emit) pending_records.push_back(rec);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      length_reg = 32'd1;
      clear_parse();
      pending_records.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 2) == 3'(REG_IMAGE_LENGTH))
        length_reg = pwdata;
      // predict before comparing so a same-edge record still lines up
      if (image_valid && image_ready) parse_image_byte(image_byte);
      if (result_valid && result_ready) begin
        if (pending_records.size() == 0) begin
          $display("%0t: result transfer with no record expected, kind %0d",
                   $time, result_kind);
          mismatch_count++;
        end else begin
          oldest = pending_records.pop_front();
          check_field("result_kind", oldest.kind, result_kind);
          check_field("segment_address", oldest.segment_address, segment_address);
          check_field("segment_length", oldest.segment_length, segment_length);
          check_field("payload_offset", oldest.payload_offset, payload_offset);
          check_field("segment_class", oldest.segment_class, segment_class);
          check_field("segment_number", oldest.segment_number, segment_number);
          check_field("parse_status", oldest.parse_status, parse_status);
          check_field("segments_found", oldest.segments_found, segments_found);
          check_field("instr_total", oldest.instr_total, instr_total);
          check_field("data_total", oldest.data_total, data_total);
          check_field("external_total", oldest.external_total, external_total);
        end
      end
    end
    records_due = pending_records.size();
  end

endmodule

### verif/firmware_segment_image_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_segment_image_parser_unit_tb
// Streams directed and random firmware images through the parser, programs
// the image length between images and mid-image, and applies random gaps
// and back-pressure; the record checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module firmware_segment_image_parser_unit_tb;
  import fsip_pkg::*;

  localparam int unsigned MAX_SEGS     = 16;
  localparam int          RANDOM_BYTES = 880;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [2:0]  LENGTH_ADDR  = 3'(REG_IMAGE_LENGTH) << 2;

  // Ways a random image gets damaged to reach the error paths
  typedef enum int {CUT_TAIL, ADD_TAIL, HUGE_BLOCK, FLIP_BYTE} damage_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        image_valid;
  logic        image_ready;
  logic [7:0]  image_byte;
  logic        result_valid;
  logic        result_ready;
  logic        result_kind;
  logic [31:0] segment_address;
  logic [31:0] segment_length;
  logic [31:0] payload_offset;
  logic [1:0]  segment_class;
  logic [3:0]  segment_number;
  logic [1:0]  parse_status;
  logic [4:0]  segments_found;
  logic [31:0] instr_total;
  logic [31:0] data_total;
  logic [31:0] external_total;

  int          mismatch_count;
  int          records_due;
  int          cycle_count;

  // Suppress all idling on both sides while set
  bit          steady;
  // Image length currently programmed into the block
  logic [31:0] cur_len;
  // Bytes of the image being assembled, in stream order
  logic [7:0]  image_q[$];

  firmware_segment_image_parser_unit #(.MAX_SEGMENTS(MAX_SEGS)) dut (.*);

  fsip_record_checker #(.MAX_SEGMENTS(MAX_SEGS)) record_check (.*);

  // Clock: 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost record ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: stall at random about 14 percent of the time, never while steady
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  // Load address spread over the instruction window, the data window, the
  // window corners and the rest of the 32-bit space
  function automatic logic [31:0] pick_address();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return 32'($urandom_range(0, 32'h3FFF));
    if (roll < 45) return DTCM_BASE + 32'($urandom_range(0, 32'h3FFF));
    if (roll < 70) return $urandom();
    if (roll < 88) begin
      case ($urandom_range(0, 6))
        0:       return ITCM_BASE;
        1:       return TCM_SPAN - 32'd1;
        2:       return TCM_SPAN;
        3:       return DTCM_BASE - 32'd1;
        4:       return DTCM_BASE + TCM_SPAN - 32'd1;
        5:       return DTCM_BASE + TCM_SPAN;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
  endfunction

  task automatic add_random(input int count);
    repeat (count) image_q.push_back(8'($urandom()));
  endtask

  // Append a block header: address and size little-endian, 8 filler bytes
  task automatic add_header(input logic [31:0] addr, input logic [31:0] size);
    for (int i = 0; i < 4; i++) image_q.push_back(addr[8*i +: 8]);
    for (int i = 0; i < 4; i++) image_q.push_back(size[8*i +: 8]);
    add_random(8);
  endtask

  task automatic add_block(input logic [31:0] addr, input int size);
    add_header(addr, 32'(size));
    add_random(size);
  endtask

  // Drop valid and hold off until every expected record has been taken,
  // then let any byte in flight finish before the caller goes on
  task automatic settle();
    image_valid <= 1'b0;
    @(posedge clk);
    while (records_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the image length: setup cycle, then access cycle
  task automatic program_length(input logic [31:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LENGTH_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_len = value;
  endtask

  // One byte transfer, with an optional gap in front of it
  task automatic send_byte(input logic [7:0] value);
    if (!steady && $urandom_range(99) < 14) begin
      image_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    image_valid <= 1'b1;
    image_byte  <= value;
    @(posedge clk);
    while (!image_ready) @(posedge clk);
  endtask

  task automatic send_queue();
    foreach (image_q[i]) send_byte(image_q[i]);
    image_q.delete();
  endtask

  // Send the assembled image as one whole image; reprogram only on a change
  // of length so equal-length images stream back to back
  task automatic run_image();
    if (32'(image_q.size()) != cur_len) program_length(32'(image_q.size()));
    send_queue();
  endtask

  initial begin
    int          streamed;
    int          blocks;
    bit          reuse;
    int          layout[$];
    logic [7:0]  junk;

    // Drive every input to a known value before the first edge
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    image_valid <= 1'b0;
    image_byte  <= '0;
    steady      = 1'b0;
    cur_len     = 32'd1;
    cycle_count = 0;
    streamed    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----

    // Reset length of one: a lone byte is a header cut short
    add_random(1);
    run_image();

    // Single zero-size block: nothing recorded, empty image
    add_header(32'h0000_1000, 32'd0);
    run_image();

    // Header completes on the final byte with a nonzero size: oversized
    add_header(ITCM_BASE, 32'd5);
    run_image();

    // Class boundaries of both windows, a skipped empty block, then an
    // oversized block whose trailing bytes must be ignored
    add_block(TCM_SPAN - 32'd1, 1);
    add_block(TCM_SPAN - 32'd1, 2);
    add_header(ITCM_BASE, 32'd0);
    add_block(DTCM_BASE + TCM_SPAN - 32'd1, 1);
    add_block(DTCM_BASE + TCM_SPAN, 1);
    add_block(DTCM_BASE - 32'd1, 1);
    add_block(32'hFFFF_FFFF, 1);
    add_block(DTCM_BASE, 3);
    add_block(ITCM_BASE, 4);
    add_header(32'h0000_0020, 32'd100);
    add_random(5);
    run_image();

    // Good block followed by a header cut off by the image end
    add_block(32'h0000_0100, 2);
    add_random(7);
    run_image();

    // Fill the segment table, then one block too many
    repeat (MAX_SEGS) add_block(pick_address(), 1);
    add_block(ITCM_BASE, 1);
    run_image();

    // Length zero stands for 2^32: largest size still does not fit; then
    // shorten the image mid-stream so it ends three bytes later
    program_length(32'd0);
    add_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_queue();
    program_length(32'd19);
    add_random(3);
    send_queue();

    // Largest length: a segment that just fits, ended early mid-payload
    program_length(32'hFFFF_FFFF);
    add_header(32'h1234_5678, 32'hFFFF_FFEF);
    add_random(4);
    send_queue();
    program_length(32'd24);
    add_random(4);
    send_queue();

    // Explicit write of the smallest length
    program_length(32'd1);
    add_random(1);
    send_queue();

    // ---- Random part: mostly well-formed images, some damaged ----
    while (streamed < RANDOM_BYTES) begin
      steady = (streamed >= 500 && streamed < 800);
      reuse  = (layout.size() != 0) && ($urandom_range(99) < 30);
      if (!reuse) begin
        layout.delete();
        blocks = ($urandom_range(99) < 5) ? $urandom_range(MAX_SEGS, MAX_SEGS + 2)
                                          : $urandom_range(0, 4);
        repeat (blocks) layout.push_back(($urandom_range(99) < 15) ? 0 : $urandom_range(1, 12));
      end
      foreach (layout[i]) add_block(pick_address(), layout[i]);
      if (!reuse && $urandom_range(99) < 20) begin
        case (damage_t'($urandom_range(0, 3)))
          CUT_TAIL: begin
            repeat ($urandom_range(1, 20)) begin
              if (image_q.size() > 1) junk = image_q.pop_back();
            end
          end
          ADD_TAIL: add_random($urandom_range(1, 24));
          HUGE_BLOCK: begin
            add_header(pick_address(), $urandom());
            add_random($urandom_range(0, 10));
          end
          default: begin
            if (image_q.size() != 0)
              image_q[$urandom_range(0, image_q.size() - 1)] = 8'($urandom());
          end
        endcase
      end
      // An image needs at least one byte; make it an empty block
      if (image_q.size() == 0) add_header(pick_address(), 32'd0);
      streamed += image_q.size();
      run_image();
    end
    steady = 1'b0;

    // Drain: wait out every expected record, then the pipeline tail
    image_valid <= 1'b0;
    @(posedge clk);
    while (records_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/fsip_pkg.sv
src/firmware_segment_image_parser_unit.sv
verif/fsip_record_checker.sv
verif/firmware_segment_image_parser_unit_tb.sv
